// ===== rtl/ring_fair_resource_arbiter_defines.svh =====
// ---------------------------------------------------------------------------
// Ring fair resource arbiter: assertion macros
// Clocked assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef RING_FAIR_RESOURCE_ARBITER_DEFINES_SVH
`define RING_FAIR_RESOURCE_ARBITER_DEFINES_SVH

`ifndef SYNTH
// Generic clocked assertion with explicit clock and active-low reset
`define RFRA_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assertion on the block clock and reset
`define RFRA_ASSERT(label, prop, msg) \
  `RFRA_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define RFRA_ASSERT_CLK(label, clk, rstn, prop, msg)
`define RFRA_ASSERT(label, prop, msg)
`endif

`endif

// ===== rtl/rfra_pkg.sv =====
// ---------------------------------------------------------------------------
// rfra_pkg
// Types and constants shared by the seat cells and the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package rfra_pkg;

  localparam int MAX_SEATS  = 8;
  localparam int COUNT_BITS = 16;
  localparam int MIN_SEATS  = 3;

  localparam int SEAT_W  = $clog2(MAX_SEATS);
  localparam int RING_W  = $clog2(MAX_SEATS + 1);
  localparam int MASK_W  = 8;
  localparam int IN_TDATA_W = ((SEAT_W + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_FIELD_W = 4;
  localparam logic [0:0] REG_ACTIVE_SEATS = 1'b0;

  typedef enum logic [1:0] {
    SEAT_THINK  = 2'd0,
    SEAT_HUNGRY = 2'd1,
    SEAT_EAT    = 2'd2
  } seat_st_e;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RECHECK = 2'd3
  } cell_op_e;

  typedef enum logic [2:0] {
    FSM_IDLE  = 3'd0,
    FSM_EXEC  = 3'd1,
    FSM_LEFT  = 3'd2,
    FSM_RIGHT = 3'd3,
    FSM_DONE  = 3'd4
  } fsm_e;

  // Command broadcast along the row of cells
  typedef struct packed {
    cell_op_e          op;
    logic [SEAT_W-1:0] seat;
  } cell_cmd_t;

  // What a cell shows its neighbors
  typedef struct packed {
    seat_st_e              state;
    logic [COUNT_BITS-1:0] count;
  } seat_view_t;

  // Per-cell outcome of the current command
  typedef struct packed {
    logic grant;
    logic err;
  } cell_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/rfra_cell.sv =====
// ---------------------------------------------------------------------------
// rfra_cell
// One seat: holds its state and meal count, checks its two neighbors.
// ---------------------------------------------------------------------------
`default_nettype none

module rfra_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [rfra_pkg::SEAT_W-1:0] my_index_i,
  input  wire rfra_pkg::cell_cmd_t         cmd_i,
  input  wire rfra_pkg::seat_view_t        left_i,
  input  wire rfra_pkg::seat_view_t        right_i,
  output rfra_pkg::seat_view_t             view_o,
  output rfra_pkg::cell_rsp_t              rsp_o
);
  import rfra_pkg::*;

  seat_st_e              state_q, state_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  hit;
  logic                  may_eat;
  logic [COUNT_BITS-1:0] count_inc;

  assign hit = (cmd_i.op != OP_NONE) && (cmd_i.seat == my_index_i);

  // Blocked by an eating neighbor or a hungrier (fewer meals) neighbor
  assign may_eat = (left_i.state != SEAT_EAT) && (right_i.state != SEAT_EAT) &&
                   !((left_i.state == SEAT_HUNGRY) && (left_i.count < count_q)) &&
                   !((right_i.state == SEAT_HUNGRY) && (right_i.count < count_q));

  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rsp_o.grant = 1'b0;
    rsp_o.err   = 1'b0;
    if (hit) begin
      case (cmd_i.op)
        OP_REQUEST: begin
          if (state_q != SEAT_THINK) begin
            rsp_o.err = 1'b1;
          end else if (may_eat) begin
            state_d     = SEAT_EAT;
            count_d     = count_inc;
            rsp_o.grant = 1'b1;
          end else begin
            state_d = SEAT_HUNGRY;
          end
        end
        OP_RELEASE: begin
          if (state_q != SEAT_EAT) begin
            rsp_o.err = 1'b1;
          end else begin
            state_d = SEAT_THINK;
          end
        end
        OP_RECHECK: begin
          if ((state_q == SEAT_HUNGRY) && may_eat) begin
            state_d     = SEAT_EAT;
            count_d     = count_inc;
            rsp_o.grant = 1'b1;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEAT_THINK;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assign view_o.state = state_q;
  assign view_o.count = count_q;

endmodule

`default_nettype wire

// ===== rtl/ring_fair_resource_arbiter.sv =====
// Sequencing: a request or a rejected item passes through the own update and
// the result load; a release passes through the own update, left recheck,
// right recheck and result load.
// Throughput: one item at a time; the sequencer stepping through the ring of
// seat cells sets the rate, which slows further while a held result waits on
// m_axis_tready.
// Reset: rst_ni is asynchronous; all seats think, counts clear, ring size 3.
// ---------------------------------------------------------------------------
// ring_fair_resource_arbiter
// Ring of seat cells sharing resources with their neighbors. A sequencer
// feeds each event to the cells and collects the grant mask and error flag.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ring_fair_resource_arbiter_defines.svh"

module ring_fair_resource_arbiter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input items
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // seat_index[SEAT_W-1:0], zero padded
  input  wire logic [rfra_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // command[0]
  input  wire logic                            s_axis_tuser,
  // Result items
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // granted_mask[7:0]
  output logic [rfra_pkg::MASK_W-1:0]          m_axis_tdata,
  // error[0]
  output logic                                 m_axis_tuser,
  // Configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rfra_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rfra_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rfra_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import rfra_pkg::*;

  // ---- Configuration register ---------------------------------------------
  logic [RING_W-1:0]      active_q, active_d;
  logic                   cfg_wr;
  logic                   cfg_sel_active;
  logic [CFG_FIELD_W-1:0] cfg_val;

  assign pready         = 1'b1;
  assign cfg_sel_active = (paddr[2] == REG_ACTIVE_SEATS);
  assign cfg_wr         = psel && penable && pwrite && pready;
  assign cfg_val        = pwdata[CFG_FIELD_W-1:0];

  // Clamp the ring size into its legal range
  always_comb begin
    active_d = active_q;
    if (cfg_wr && cfg_sel_active) begin
      if (cfg_val < CFG_FIELD_W'(MIN_SEATS)) begin
        active_d = RING_W'(MIN_SEATS);
      end else if (cfg_val > CFG_FIELD_W'(MAX_SEATS)) begin
        active_d = RING_W'(MAX_SEATS);
      end else begin
        active_d = RING_W'(cfg_val);
      end
    end
  end

  assign prdata = cfg_sel_active ? CFG_DATA_W'(active_q) : '0;

  // ---- Seat cells -----------------------------------------------------------
  cell_cmd_t                 cell_cmd;
  seat_view_t [MAX_SEATS-1:0] view;
  seat_view_t [MAX_SEATS-1:0] left_view;
  seat_view_t [MAX_SEATS-1:0] right_view;
  cell_rsp_t  [MAX_SEATS-1:0] rsp;
  logic       [MAX_SEATS-1:0] grant_vec;
  logic       [MAX_SEATS-1:0] err_vec;
  logic [SEAT_W-1:0]          last_seat;

  // Seat at the wrap point of the ring
  assign last_seat = SEAT_W'(active_q - 1'b1);

  for (genvar i = 0; i < MAX_SEATS; i++) begin : g_cell
    // Close the ring at the active size; seats beyond it are left out
    if (i == 0) begin : g_first
      assign left_view[i] = view[last_seat];
    end else begin : g_mid
      assign left_view[i] = view[i-1];
    end
    assign right_view[i] = (RING_W'(i + 1) == active_q) ? view[0]
                                                         : view[(i + 1) % MAX_SEATS];

    rfra_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .my_index_i (SEAT_W'(i)),
      .cmd_i      (cell_cmd),
      .left_i     (left_view[i]),
      .right_i    (right_view[i]),
      .view_o     (view[i]),
      .rsp_o      (rsp[i])
    );

    assign grant_vec[i] = rsp[i].grant;
    assign err_vec[i]   = rsp[i].err;
  end

  // ---- Sequencer ------------------------------------------------------------
  fsm_e              state_q, state_d;
  cmd_e              cmd_q;
  logic [SEAT_W-1:0] seat_q;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic              err_q, err_d;
  logic              range_err;
  logic [SEAT_W-1:0] left_seat;
  logic [SEAT_W-1:0] right_seat;
  logic              in_accept;
  logic              out_load;
  logic [MASK_W-1:0] grant_mask;

  logic              m_valid_q, m_valid_d;
  logic [MASK_W-1:0] m_mask_q;
  logic              m_err_q;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign range_err = (RING_W'(seat_q) >= active_q);
  assign left_seat  = (seat_q == '0) ? last_seat : seat_q - 1'b1;
  assign right_seat = ((RING_W'(seat_q) + 1'b1) == active_q) ? '0 : seat_q + 1'b1;

  // Seats above the result width are dropped from the mask
  always_comb begin
    grant_mask = '0;
    for (int j = 0; j < MASK_W; j++) begin
      if (j < MAX_SEATS) begin
        grant_mask[j] = grant_vec[j];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (range_err || (cmd_q == CMD_REQUEST) || (|err_vec)) begin
          state_d = FSM_DONE;
        end else begin
          state_d = FSM_LEFT;
        end
      end
      FSM_LEFT: begin
        state_d = FSM_RIGHT;
      end
      FSM_RIGHT: begin
        state_d = FSM_DONE;
      end
      FSM_DONE: begin
        if (out_load) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: cell command, accumulators, result register
  always_comb begin
    s_axis_tready = 1'b0;
    cell_cmd.op   = OP_NONE;
    cell_cmd.seat = seat_q;
    mask_d        = mask_q;
    err_d         = err_q;
    out_load      = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        s_axis_tready = 1'b1;
        mask_d        = '0;
        err_d         = 1'b0;
      end
      FSM_EXEC: begin
        if (range_err) begin
          err_d = 1'b1;
        end else begin
          cell_cmd.op = (cmd_q == CMD_REQUEST) ? OP_REQUEST : OP_RELEASE;
          mask_d      = mask_q | grant_mask;
          err_d       = err_q | (|err_vec);
        end
      end
      FSM_LEFT: begin
        cell_cmd.op   = OP_RECHECK;
        cell_cmd.seat = left_seat;
        mask_d        = mask_q | grant_mask;
      end
      FSM_RIGHT: begin
        cell_cmd.op   = OP_RECHECK;
        cell_cmd.seat = right_seat;
        mask_d        = mask_q | grant_mask;
      end
      FSM_DONE: begin
        out_load = !m_valid_q || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Hold the result until taken; reload when free or being drained
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      active_q  <= RING_W'(MIN_SEATS);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    err_q  <= err_d;
    if (in_accept) begin
      cmd_q  <= cmd_e'(s_axis_tuser);
      seat_q <= s_axis_tdata[SEAT_W-1:0];
    end
    if (out_load) begin
      m_mask_q <= mask_q;
      m_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_mask_q;
  assign m_axis_tuser  = m_err_q;

  // ---- Assertions -----------------------------------------------------------
  `RFRA_ASSERT(a_one_grant_per_step, $onehot0(grant_vec), "more than one seat granted in a step")
  `RFRA_ASSERT(a_err_no_grant, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0), "rejected item carries grants")
  `RFRA_ASSERT(a_left_after_release, (state_q == FSM_LEFT) |-> ($past(state_q) == FSM_EXEC && cmd_q == CMD_RELEASE), "recheck without a release")
  `RFRA_ASSERT(a_grant_in_ring, m_axis_tvalid |-> ((m_axis_tdata >> active_q) == '0), "grant outside the active ring")

endmodule

`default_nettype wire

// ===== dv/ring_fair_resource_arbiter_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ring_fair_resource_arbiter_tb
// Drives request and release events into the seat ring and checks every
// result against a typed expectation or an in-bench model of the ring. A
// directed table covers range errors, wrong-state commands, blocking,
// fairness and ring resizing. Random phases follow at random ring sizes,
// with idle gaps on both stream sides.
// ---------------------------------------------------------------------------

module ring_fair_resource_arbiter_tb;
  import rfra_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_WAIT     = 10;
  // Leave a margin beyond the internal steps of a release
  localparam int DRAIN_CYCLES = 8;
  // About 540 items, each with random gaps and stalls on either side; the
  // limit only stops a hung run
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 85;
  localparam int NOISE_PCT    = 15;
  localparam int DIR_N        = 32;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              err;
  } outcome_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  // One step of the directed sequence. An item row can carry a typed
  // expectation; a config row writes cfg_val to the ring size register.
  typedef struct packed {
    row_kind_e         kind;
    cmd_e              cmd;
    logic [SEAT_W-1:0] seat;
    logic              typed;
    logic [MASK_W-1:0] mask;
    logic              err;
    logic [3:0]        cfg_val;
  } dir_row_t;

  // Field order: kind, command, seat, typed, mask, error, register value
  dir_row_t directed_rows [DIR_N] = '{
    // Ring of 3 after reset: range and wrong-state errors first
    '{ROW_ITEM, CMD_REQUEST, 3'd7, 1'b1, 8'h00, 1'b1, 4'd0},  // top seat, outside ring
    '{ROW_ITEM, CMD_REQUEST, 3'd3, 1'b1, 8'h00, 1'b1, 4'd0},  // first seat past ring
    '{ROW_ITEM, CMD_RELEASE, 3'd0, 1'b1, 8'h00, 1'b1, 4'd0},  // release while thinking
    '{ROW_ITEM, CMD_REQUEST, 3'd0, 1'b1, 8'h01, 1'b0, 4'd0},  // idle ring, grant at once
    '{ROW_ITEM, CMD_REQUEST, 3'd0, 1'b1, 8'h00, 1'b1, 4'd0},  // request while eating
    '{ROW_ITEM, CMD_REQUEST, 3'd1, 1'b1, 8'h00, 1'b0, 4'd0},  // neighbor eats, wait
    '{ROW_ITEM, CMD_REQUEST, 3'd1, 1'b1, 8'h00, 1'b1, 4'd0},  // request while hungry
    '{ROW_ITEM, CMD_RELEASE, 3'd1, 1'b1, 8'h00, 1'b1, 4'd0},  // release while hungry
    '{ROW_ITEM, CMD_REQUEST, 3'd2, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_RELEASE, 3'd0, 1'b0, 8'h00, 1'b0, 4'd0},  // left recheck grants
    '{ROW_ITEM, CMD_RELEASE, 3'd2, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_RELEASE, 3'd1, 1'b0, 8'h00, 1'b0, 4'd0},
    // Full ring of 8
    '{ROW_CFG,  CMD_REQUEST, 3'd0, 1'b0, 8'h00, 1'b0, 4'd8},
    '{ROW_ITEM, CMD_REQUEST, 3'd7, 1'b1, 8'h80, 1'b0, 4'd0},  // top mask bit
    '{ROW_ITEM, CMD_REQUEST, 3'd6, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_REQUEST, 3'd0, 1'b0, 8'h00, 1'b0, 4'd0},  // wraps to seat 7
    '{ROW_ITEM, CMD_RELEASE, 3'd7, 1'b0, 8'h00, 1'b0, 4'd0},  // both sides granted
    '{ROW_ITEM, CMD_RELEASE, 3'd0, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_RELEASE, 3'd6, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_REQUEST, 3'd2, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_REQUEST, 3'd1, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_REQUEST, 3'd0, 1'b0, 8'h00, 1'b0, 4'd0},  // hungry neighbor ate less
    '{ROW_ITEM, CMD_RELEASE, 3'd2, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_RELEASE, 3'd1, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_RELEASE, 3'd0, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_REQUEST, 3'd5, 1'b0, 8'h00, 1'b0, 4'd0},
    // Shrink with seat 5 still eating (0 clamps to 3), then grow back
    '{ROW_CFG,  CMD_REQUEST, 3'd0, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_REQUEST, 3'd5, 1'b1, 8'h00, 1'b1, 4'd0},  // cut off from the ring
    '{ROW_ITEM, CMD_REQUEST, 3'd2, 1'b0, 8'h00, 1'b0, 4'd0},  // seat 3 is no neighbor
    '{ROW_CFG,  CMD_REQUEST, 3'd0, 1'b0, 8'h00, 1'b0, 4'd15}, // clamps to 8
    '{ROW_ITEM, CMD_RELEASE, 3'd5, 1'b0, 8'h00, 1'b0, 4'd0},
    '{ROW_ITEM, CMD_RELEASE, 3'd2, 1'b0, 8'h00, 1'b0, 4'd0}
  };

  // Clock, reset and block ports
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  wire                   s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire  [MASK_W-1:0]     m_axis_tdata;
  wire                   m_axis_tuser;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr         = '0;
  logic [CFG_DATA_W-1:0] pwdata        = '0;
  wire  [CFG_DATA_W-1:0] prdata;
  wire                   pready;

  // Ring model: per-seat state, meal counts and the current ring size
  seat_st_e              occ   [MAX_SEATS];
  logic [COUNT_BITS-1:0] meals [MAX_SEATS];
  int                    ring_n;

  // Results still owed by the block, oldest first
  outcome_t    pending [$];
  int          mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  ring_fair_resource_arbiter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // seat_index[2:0], zero padded
    .s_axis_tuser  (s_axis_tuser),   // command[0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // granted_mask[7:0]
    .m_axis_tuser  (m_axis_tuser),   // error[0]
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Watchdog: stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_cnt++;
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // -------------------------------------------------------------------------
  // Ring model
  // -------------------------------------------------------------------------
  function automatic int seat_left(int s);
    return (s + ring_n - 1) % ring_n;
  endfunction

  function automatic int seat_right(int s);
    return (s + 1) % ring_n;
  endfunction

  // A seat may start eating if no neighbor eats and no hungry neighbor has
  // eaten fewer meals than it has
  function automatic bit may_dine(int s);
    int l;
    int r;
    l = seat_left(s);
    r = seat_right(s);
    if (occ[l] == SEAT_EAT || occ[r] == SEAT_EAT) return 1'b0;
    if (occ[l] == SEAT_HUNGRY && meals[l] < meals[s]) return 1'b0;
    if (occ[r] == SEAT_HUNGRY && meals[r] < meals[s]) return 1'b0;
    return 1'b1;
  endfunction

  // Grant a hungry seat if allowed; the meal count sticks at its maximum
  function automatic logic [MASK_W-1:0] try_serve(int s);
    if (occ[s] != SEAT_HUNGRY || !may_dine(s)) return '0;
    occ[s] = SEAT_EAT;
    if (meals[s] != COUNT_MAX) meals[s]++;
    return MASK_W'(1) << s;
  endfunction

  // Apply one event to the model and return the result it must produce
  function automatic outcome_t arbitrate(cmd_e c, int s);
    outcome_t o;
    o = '0;
    if (s >= ring_n) begin
      o.err = 1'b1;
    end else if (c == CMD_REQUEST) begin
      if (occ[s] != SEAT_THINK) begin
        o.err = 1'b1;
      end else begin
        occ[s] = SEAT_HUNGRY;
        o.mask = try_serve(s);
      end
    end else begin
      if (occ[s] != SEAT_EAT) begin
        o.err = 1'b1;
      end else begin
        // Recheck the left neighbor before the right one
        occ[s] = SEAT_THINK;
        o.mask = try_serve(seat_left(s));
        o.mask |= try_serve(seat_right(s));
      end
    end
    return o;
  endfunction

  // -------------------------------------------------------------------------
  // Stream and register drivers
  // -------------------------------------------------------------------------

  // Offer one event after a random gap; on acceptance queue its result,
  // either the typed one or what the model predicts
  task automatic offer_event(input cmd_e c, input logic [SEAT_W-1:0] s,
                             input bit typed, input outcome_t want);
    int       gap;
    outcome_t predicted;
    gap = $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(s);
    s_axis_tuser  <= c;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predicted = arbitrate(c, int'(s));
    pending.push_back(typed ? want : predicted);
  endtask

  // Drop valid, wait until every owed result is back, then let the block
  // finish any internal step before touching the register
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the ring size with random upper bits, then read it back.
  // Write and read share one select phase: setup, access, setup, access.
  task automatic set_ring(input logic [3:0] v);
    logic [31:0] junk;
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * REG_ACTIVE_SEATS);
    pwdata  <= {junk[31:4], v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // Written at this edge; values outside the legal range clamp
    ring_n  = (v < MIN_SEATS) ? MIN_SEATS : (v > MAX_SEATS) ? MAX_SEATS : int'(v);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== CFG_DATA_W'(ring_n))
      note_mismatch("ring size readback", prdata, 32'(ring_n));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Result side: stall at random, check each result against the oldest
  // expectation
  // -------------------------------------------------------------------------
  initial begin : result_sink
    outcome_t want;
    int       stall;
    forever begin
      stall = $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1 || m_axis_tready !== 1'b1);
      if (pending.size() == 0) begin
        note_mismatch("unexpected result", 32'({m_axis_tdata, m_axis_tuser}), '0);
      end else begin
        want = pending.pop_front();
        if (m_axis_tdata !== want.mask)
          note_mismatch("granted mask", 32'(m_axis_tdata), 32'(want.mask));
        if (m_axis_tuser !== want.err)
          note_mismatch("error flag", 32'(m_axis_tuser), 32'(want.err));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    outcome_t          want;
    cmd_e              c;
    logic [SEAT_W-1:0] s;

    for (int i = 0; i < MAX_SEATS; i++) begin
      occ[i]   = SEAT_THINK;
      meals[i] = '0;
    end
    ring_n = MIN_SEATS;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: ring size 3 out of reset, then resized along the way
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        set_ring(directed_rows[i].cfg_val);
      end else begin
        want.mask = directed_rows[i].mask;
        want.err  = directed_rows[i].err;
        offer_event(directed_rows[i].cmd, directed_rows[i].seat,
                    directed_rows[i].typed, want);
      end
    end

    // Random phases. Each picks a fresh ring size from the whole field,
    // so seats left outside a shrunk ring keep their state. Most events
    // are legal for the seat's state; the rest are noise.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      set_ring(4'($urandom_range(0, 15)));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < NOISE_PCT) begin
          c = cmd_e'($urandom_range(0, 1));
          s = SEAT_W'($urandom_range(0, MAX_SEATS - 1));
        end else begin
          s = SEAT_W'($urandom_range(0, ring_n - 1));
          case (occ[s])
            SEAT_EAT:   c = CMD_RELEASE;
            SEAT_THINK: c = CMD_REQUEST;
            default:    c = cmd_e'($urandom_range(0, 1));
          endcase
        end
        offer_event(c, s, 1'b0, '0);
      end
    end

    // Drain, then watch a little longer for stray results
    settle();
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
